FILE: hw/rtl/uitf_pkg.sv
// Shared constants for the UART idle-timeout framer.
// No dependencies; imported by uart_idle_timeout_framer_core.
`default_nettype none

package uitf_pkg;

  // Frame buffer geometry
  localparam int unsigned BufferDepth = 64;
  localparam int unsigned CountW      = $clog2(BufferDepth + 1);
  localparam int unsigned AddrW       = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  // Idle counter and timeout register
  localparam int unsigned IdleW            = 16;
  localparam logic [IdleW-1:0] IdleMax     = '1;
  localparam logic [IdleW-1:0] TimeoutReset = 16'd10;

  // Input opcodes
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

endpackage : uitf_pkg

`default_nettype wire

FILE: hw/rtl/uart_idle_timeout_framer_core.sv
// UART idle-timeout framer: collects received bytes and emits them as a frame.
// Frame bytes are held in a 64 x 8 synchronous RAM; depends on uitf_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one beat per event: op_i = 0 is a
//    received byte on rx_byte_i, op_i = 1 is one timer tick.
//  - Output channel (out_valid_o / out_ready_i) carries one beat per byte of a closed
//    frame, with frame_length_o on every byte and last_of_frame_o on the final byte.
//  - idle_timeout is written through idle_timeout_we_i / idle_timeout_i; write it only
//    while no frame is being flushed.
//  - While collecting, one input beat is taken every cycle (store write or counter update).
//  - A closing beat switches to a flush: the RAM is read one byte per cycle while the
//    receiver keeps up, and each byte goes from the registered RAM read into the output
//    register; the input stays closed for the whole flush.
//  - The flush rate is set by the single RAM read port and the one-entry read stage.
//  - When the receiver stalls, reads stop until the output register frees; input stays
//    closed until the flush finishes. Outside a flush, input is taken even while the
//    last result waits in the output register.
//  - Reset empties the buffer, clears the idle counter and sets the timeout to 10.
//    The RAM contents are not cleared; only written entries are ever read.
`default_nettype none

module uart_idle_timeout_framer_core
  import uitf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              idle_timeout_we_i,
  input  wire logic [IdleW-1:0]  idle_timeout_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              op_i,
  input  wire logic [7:0]        rx_byte_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             frame_byte_o,
  output logic [CountW-1:0]      frame_length_o,
  output logic                   last_of_frame_o
);

  typedef enum logic {
    StCollect,
    StFlush
  } state_e;

  state_e            state_q, state_d;
  logic [IdleW-1:0]  timeout_q;
  logic [IdleW-1:0]  idle_q, idle_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CountW-1:0] rd_ptr_q, rd_ptr_d;
  logic              rd_pending_q, rd_pending_d;
  logic              rd_last_q, rd_last_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic [CountW-1:0] out_len_q, out_len_d;
  logic [7:0]        out_byte_q, out_byte_d;

  logic              in_fire;
  logic [IdleW-1:0]  idle_inc;
  logic              wr_en;
  logic              rd_en;
  logic              rd_move;
  logic [CountW-1:0] rd_ptr_inc;
  logic [7:0]        rdata_q;

  logic [7:0] frame_store [BufferDepth];

  assign in_ready_o = (state_q == StCollect);
  assign in_fire    = in_valid_i && in_ready_o;
  assign idle_inc   = (idle_q != IdleMax) ? idle_q + 1'b1 : idle_q;
  assign rd_ptr_inc = rd_ptr_q + 1'b1;

  // read stage hands its byte to the output register when that is free or draining
  assign rd_move = rd_pending_q && (!out_valid_q || out_ready_i);
  assign rd_en   = (state_q == StFlush) && (rd_ptr_q != len_q)
                   && (!rd_pending_q || rd_move);

  always_comb begin
    state_d      = state_q;
    idle_d       = idle_q;
    count_d      = count_q;
    len_d        = len_q;
    rd_ptr_d     = rd_ptr_q;
    rd_pending_d = rd_pending_q;
    rd_last_d    = rd_last_q;
    out_valid_d  = out_valid_q;
    out_last_d   = out_last_q;
    out_len_d    = out_len_q;
    out_byte_d   = out_byte_q;
    wr_en        = 1'b0;

    unique case (state_q)
      StCollect: begin
        if (in_fire) begin
          if (op_i == OpTick) begin
            idle_d = idle_inc;
            if ((count_q != '0) && (idle_inc > timeout_q)) begin
              state_d  = StFlush;
              len_d    = count_q;
              rd_ptr_d = '0;
              count_d  = '0;
            end
          end else if ((count_q != '0) && (idle_q > timeout_q)) begin
            // byte arriving past the timeout closes the frame and is dropped
            state_d  = StFlush;
            len_d    = count_q;
            rd_ptr_d = '0;
            count_d  = '0;
          end else if (count_q >= CountW'(BufferDepth)) begin
            count_d = '0;  // overflow: whole frame discarded
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            idle_d  = '0;
          end
        end
      end
      StFlush: begin
        if ((rd_ptr_q == len_q) && !rd_pending_q) begin
          state_d = StCollect;
        end
      end
      default: state_d = StCollect;
    endcase

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rd_move) begin
      out_valid_d  = 1'b1;
      out_byte_d   = rdata_q;
      out_last_d   = rd_last_q;
      out_len_d    = len_q;
      rd_pending_d = 1'b0;
    end
    if (rd_en) begin
      rd_pending_d = 1'b1;
      rd_last_d    = (rd_ptr_inc == len_q);
      rd_ptr_d     = rd_ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StCollect;
      timeout_q    <= TimeoutReset;
      idle_q       <= '0;
      count_q      <= '0;
      len_q        <= '0;
      rd_ptr_q     <= '0;
      rd_pending_q <= 1'b0;
      rd_last_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_len_q    <= '0;
    end else begin
      state_q      <= state_d;
      if (idle_timeout_we_i) begin
        timeout_q <= idle_timeout_i;
      end
      idle_q       <= idle_d;
      count_q      <= count_d;
      len_q        <= len_d;
      rd_ptr_q     <= rd_ptr_d;
      rd_pending_q <= rd_pending_d;
      rd_last_q    <= rd_last_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
      out_len_q    <= out_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  // Frame RAM: one write port (collect), one registered read port (flush)
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_store[count_q[AddrW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= frame_store[rd_ptr_q[AddrW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign frame_length_o  = out_len_q;
  assign last_of_frame_o = out_last_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(BufferDepth))
    else $error("byte count beyond buffer depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (rd_ptr_q <= len_q))
    else $error("flush read pointer past frame length");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("frame RAM written and read in the same cycle");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> (count_q == '0))
    else $error("buffer refilled during flush");

  a_pending_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pending_q |-> (state_q == StFlush))
    else $error("read stage busy outside flush");

endmodule : uart_idle_timeout_framer_core

`default_nettype wire

FILE: bench/uart_idle_timeout_framer_core_tb.sv
// Testbench for uart_idle_timeout_framer_core: directed and random byte/tick traffic,
// each result beat checked against an in-bench frame model. Depends on uitf_pkg.
`timescale 1ns / 1ps

module uart_idle_timeout_framer_core_tb;
  import uitf_pkg::*;

  localparam int unsigned HoldOffCycles       = 300;
  localparam int unsigned SettleCycles        = 8;
  localparam int unsigned WatchdogLimit       = 4000;
  localparam int unsigned RandomItemsPerPhase = 12;

  typedef struct packed {
    logic [7:0]        data;
    logic [CountW-1:0] len;
    logic              last;
  } frame_beat_t;

  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              idle_timeout_we_i = 1'b0;
  logic [IdleW-1:0]  idle_timeout_i    = '0;
  logic              in_valid_i        = 1'b0;
  logic              in_ready_o;
  logic              op_i              = OpByte;
  logic [7:0]        rx_byte_i         = '0;
  logic              out_valid_o;
  logic              out_ready_i       = 1'b0;
  logic [7:0]        frame_byte_o;
  logic [CountW-1:0] frame_length_o;
  logic              last_of_frame_o;

  // frame model state
  logic [7:0]       model_store [BufferDepth];
  int unsigned      model_fill    = 0;
  logic [IdleW-1:0] model_idle    = '0;
  logic [IdleW-1:0] model_timeout = TimeoutReset;
  frame_beat_t      pending_beats [$];

  bit          calm          = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;

  uart_idle_timeout_framer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .idle_timeout_we_i(idle_timeout_we_i),
    .idle_timeout_i   (idle_timeout_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .frame_length_o   (frame_length_o),
    .last_of_frame_o  (last_of_frame_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Tick advances the idle count first; a byte checks for close before it is stored.
  function automatic void advance_frame_model(input logic op, input logic [7:0] data);
    if (op == OpTick && model_idle != IdleMax) model_idle++;
    if (model_fill != 0 && model_idle > model_timeout) begin
      for (int k = 0; k < model_fill; k++) begin
        pending_beats.push_back('{model_store[k], CountW'(model_fill), k == model_fill - 1});
      end
      model_fill = 0;
    end else if (op == OpByte) begin
      if (model_fill >= BufferDepth) begin
        model_fill = 0;  // overflow drops the whole frame
      end else begin
        model_store[model_fill] = data;
        model_fill++;
        model_idle = '0;
      end
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic offer_event(input logic op, input logic [7:0] data);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    rx_byte_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    advance_frame_model(op, data);
  endtask

  task automatic send_byte(input logic [7:0] data);
    offer_event(OpByte, data);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) offer_event(OpTick, 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_idle_timeout(input logic [IdleW-1:0] value);
    wait_drained();
    idle_timeout_we_i <= 1'b1;
    idle_timeout_i    <= value;
    @(posedge clk_i);
    idle_timeout_we_i <= 1'b0;
    model_timeout = value;
  endtask

  // Reset value 10: ten ticks hold the frame, the eleventh closes it.
  task automatic test_default_timeout();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_ticks(10);
    send_byte(8'h80);
    send_ticks(11);
  endtask

  task automatic test_zero_timeout();
    set_idle_timeout('0);
    send_byte(8'hA5);
    send_ticks(1);
    send_ticks(3);  // empty store stays silent
    send_byte(8'h5A);
    send_byte(8'h3C);
    send_ticks(1);
  endtask

  // Lowering the timeout under a held frame makes the next byte close it and be dropped.
  task automatic test_byte_at_timeout();
    set_idle_timeout(16'd5);
    send_byte(8'h11);
    send_byte(8'h22);
    send_ticks(3);
    set_idle_timeout(16'd1);
    send_byte(8'h33);
    send_ticks(1);
    send_byte(8'h44);
    send_ticks(2);
  endtask

  task automatic test_full_store();
    set_idle_timeout(16'd3);
    calm = 1'b1;
    repeat (BufferDepth) send_byte(8'($urandom));
    send_ticks(4);
    repeat (BufferDepth + 1) send_byte(8'($urandom));
    send_byte(8'h77);
    send_ticks(4);
    calm = 1'b0;
  endtask

  // Timeout at the top of the range holds the frame; a lower timeout then closes it.
  task automatic test_max_timeout();
    set_idle_timeout(IdleMax);
    send_byte(8'h81);
    send_ticks(20);
    send_byte(8'h7E);
    send_ticks(20);
    set_idle_timeout(16'd3);
    send_ticks(1);
  endtask

  task automatic test_receiver_hold_off();
    set_idle_timeout(16'd2);
    hold_requests++;
    repeat (30) send_byte(8'($urandom));
    send_ticks(3);
    repeat (10) send_byte(8'($urandom));
    send_ticks(3);
  endtask

  task automatic test_random_frames();
    logic [IdleW-1:0] phase_timeout [5];
    int unsigned      phase_items;
    int unsigned      len;
    int unsigned      ticks;
    phase_timeout = '{16'd1, 16'd0, 16'd4, 16'd2, 16'd7};
    for (int p = 0; p < 5; p++) begin
      set_idle_timeout(phase_timeout[p]);
      calm = (p == 2);
      phase_items = 0;
      while (phase_items < RandomItemsPerPhase) begin
        if ($urandom_range(99) < 10) begin
          len = $urandom_range(1, 4);
          repeat (len) offer_event(1'($urandom), 8'($urandom));
          phase_items += len;
        end
        len = ($urandom_range(99) < 8) ? $urandom_range(BufferDepth - 2, BufferDepth + 2)
                                       : $urandom_range(1, 8);
        repeat (len) send_byte(8'($urandom));
        // mostly enough ticks to close; sometimes too few so the frame keeps growing
        if ($urandom_range(99) < 80) ticks = phase_timeout[p] + 1 + $urandom_range(0, 2);
        else ticks = $urandom_range(0, phase_timeout[p]);
        send_ticks(ticks);
        phase_items += len + ticks;
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldOffCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        note_mismatch($sformatf("beat with nothing expected, frame_byte %02h", frame_byte_o));
      end else begin
        want = pending_beats.pop_front();
        if (frame_byte_o !== want.data)
          note_mismatch($sformatf("frame_byte: expected %02h, got %02h", want.data,
                                  frame_byte_o));
        if (frame_length_o !== want.len)
          note_mismatch($sformatf("frame_length: expected %0d, got %0d", want.len,
                                  frame_length_o));
        if (last_of_frame_o !== want.last)
          note_mismatch($sformatf("last_of_frame: expected %0b, got %0b", want.last,
                                  last_of_frame_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timeout();
    test_zero_timeout();
    test_byte_at_timeout();
    test_full_store();
    test_max_timeout();
    test_receiver_hold_off();
    test_random_frames();
    wait_drained();
    repeat (4 * SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
